FILE: rtl/core/drp_pkg.sv
// Shared types and constants for the dead-reckoning position tracker.
// Holds the item structs, operation codes, state encoding and the CORDIC angle table.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_TURN    = 2'd1,
        OP_ADVANCE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_CORDIC,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] magnitude;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [24:0]        heading_deg;
        logic               saturated;
    } t_out_item;

    localparam logic [24:0] FULL_TURN     = 25'd23592960;
    localparam logic [24:0] QUARTER_TURN  = 25'd5898240;
    localparam logic [24:0] HALF_TURN     = 25'd11796480;
    localparam logic [24:0] THREE_QUARTER = 25'd17694720;

    // The heading sum is biased by 128 full turns so that it is never negative,
    // then reduced by trial subtraction of the full turn scaled from 256 down to 1.
    localparam logic [33:0] WRAP_OFFSET   = 34'd3019898880;
    localparam logic [33:0] WRAP_DIV_INIT = 34'd6039797760;
    localparam int          WRAP_STEPS    = 9;

    localparam logic signed [31:0] CORDIC_START = 32'sd652032874;

    localparam int MUL_DIGIT  = 4;
    localparam int MUL_DIGITS = 8;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    function automatic logic [31:0] atan_q24(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489088;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            5'd20: v = 32'd917;
            5'd21: v = 32'd458;
            5'd22: v = 32'd229;
            5'd23: v = 32'd115;
            5'd24: v = 32'd57;
            5'd25: v = 32'd29;
            5'd26: v = 32'd14;
            5'd27: v = 32'd7;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/drp_wrap.sv
// Serial heading reduction: adds a turn to the heading and reduces it modulo 360 degrees.
// One trial subtraction per cycle against a shift register holding the scaled full turn.
// Depends on drp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drp_wrap (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [24:0]        i_heading,
    input  wire logic signed [31:0] i_magnitude,
    output logic                    o_done,
    output logic [24:0]             o_heading
);
    import drp_pkg::*;

    localparam int CNT_W = $clog2(WRAP_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [33:0]      r_rem;
    logic [33:0]      r_div;
    logic [33:0]      w_sum;

    assign w_sum = {9'd0, i_heading} + 34'(i_magnitude) + WRAP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(WRAP_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WRAP_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_sum;
            r_div <= WRAP_DIV_INIT;
        end else if (r_busy) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_heading = r_rem[24:0];

endmodule

`default_nettype wire

FILE: rtl/core/drp_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a heading in Q2.30.
// The heading is split into a quadrant and a residual angle below 90 degrees.
// Depends on drp_pkg for the angle table and the start vector.
`timescale 1ns / 1ps
`default_nettype none

module drp_cordic #(
    parameter int ITERATIONS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [24:0]        i_heading,
    output logic                    o_done,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);
    import drp_pkg::*;

    localparam int CNT_W = $clog2(ITERATIONS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_i;
    logic [1:0]         r_q;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [32:0] r_z;

    logic [1:0]         w_q;
    logic [24:0]        w_base;
    logic [24:0]        w_resid;
    logic [4:0]         w_idx;
    logic signed [32:0] w_angle;
    logic signed [31:0] w_dx;
    logic signed [31:0] w_dy;

    always_comb begin
        if (i_heading >= THREE_QUARTER) begin
            w_q    = 2'd3;
            w_base = THREE_QUARTER;
        end else if (i_heading >= HALF_TURN) begin
            w_q    = 2'd2;
            w_base = HALF_TURN;
        end else if (i_heading >= QUARTER_TURN) begin
            w_q    = 2'd1;
            w_base = QUARTER_TURN;
        end else begin
            w_q    = 2'd0;
            w_base = 25'd0;
        end
        w_resid = i_heading - w_base;
    end

    assign w_idx   = 5'(r_i);
    assign w_angle = $signed({1'b0, atan_q24(w_idx)});
    assign w_dx    = r_y >>> r_i;
    assign w_dy    = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == CNT_W'(ITERATIONS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CNT_W'(ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_q;
            r_x <= CORDIC_START;
            r_y <= '0;
            r_z <= $signed({w_resid, 8'd0});
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_angle;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_angle;
            end
        end
    end

    always_comb begin
        case (r_q)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/drp_smul.sv
// Digit-serial signed multiplier, four bits of the multiplier per cycle.
// Produces the product of a Q16.16 distance and a Q2.30 trig value rounded to Q18.16.
// Depends on drp_pkg for the digit size.
`timescale 1ns / 1ps
`default_nettype none

module drp_smul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_mult,
    input  wire logic signed [31:0] i_mcand,
    output logic                    o_done,
    output logic signed [33:0]      o_delta
);
    import drp_pkg::*;

    localparam int CNT_W = $clog2(MUL_DIGITS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [36:0] r_acc;
    logic [31:0]        r_lo;
    logic signed [31:0] r_mcand;

    logic                      w_last;
    logic signed [MUL_DIGIT:0] w_dig;
    logic signed [36:0]        w_pp;
    logic signed [36:0]        w_sum;

    assign w_last = (r_cnt == CNT_W'(MUL_DIGITS - 1));

    // The top digit of the multiplier carries its sign.
    assign w_dig = w_last ? $signed({r_lo[MUL_DIGIT-1], r_lo[MUL_DIGIT-1:0]})
                          : $signed({1'b0, r_lo[MUL_DIGIT-1:0]});
    assign w_pp  = 37'(w_dig) * 37'(r_mcand);
    assign w_sum = r_acc + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_lo    <= i_mult;
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_acc <= w_sum >>> MUL_DIGIT;
            r_lo  <= {w_sum[MUL_DIGIT-1:0], r_lo[31:MUL_DIGIT]};
        end
    end

    // Rounding to Q18.16 adds half an output unit, so ties go towards plus infinity.
    assign o_delta = $signed({r_acc[31:0], r_lo[31:30]}) + $signed({33'd0, r_lo[29]});
    assign o_done  = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/dead_reckoning_position_tracker.sv
// Dead-reckoning position tracker: Q16.16 position and Q9.16 heading, one result per item.
// Instantiates drp_wrap, drp_cordic and two drp_smul lanes; depends on drp_pkg.
//
// The block takes one item at a time and returns one result item for each. A start item or
// an unused operation code goes straight to its result, a turn waits for the nine-step
// serial modulo reduction, and an advance waits for the CORDIC iterations followed by the
// eight-digit serial multipliers. A finished result sits in an output register, so the
// next item is taken while it waits; a stalled output delays only the completion of that
// next item. Saturation is flagged only on an advance that clipped x or y.
`timescale 1ns / 1ps
`default_nettype none

module dead_reckoning_position_tracker #(
    parameter int ANGLE_ITERATIONS = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire drp_pkg::t_in_item   i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output drp_pkg::t_out_item       o_out_item,
    input  wire logic                i_out_stall
);
    import drp_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [24:0]        r_heading;
    logic               r_clip;
    logic signed [31:0] r_mag;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_wrap_start;
    logic               w_wrap_done;
    logic [24:0]        w_wrap_heading;
    logic               w_cordic_start;
    logic               w_cordic_done;
    logic signed [31:0] w_cos;
    logic signed [31:0] w_sin;
    logic               w_mul_done_x;
    logic               w_mul_done_y;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [34:0] w_sum_x;
    logic signed [34:0] w_sum_y;

    function automatic logic is_clip(input logic signed [34:0] v);
        return (v > 35'(POS_MAX)) || (v < 35'(POS_MIN));
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < 35'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign o_in_stall     = (r_state != ST_IDLE);
    assign w_in_acc       = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free     = !r_out_valid || !i_out_stall;
    assign w_wrap_start   = w_in_acc && (i_in_item.operation == OP_TURN);
    assign w_cordic_start = w_in_acc && (i_in_item.operation == OP_ADVANCE);

    drp_wrap u_wrap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_wrap_start),
        .i_heading   (r_heading),
        .i_magnitude (i_in_item.magnitude),
        .o_done      (w_wrap_done),
        .o_heading   (w_wrap_heading)
    );

    drp_cordic #(
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cordic_start),
        .i_heading (r_heading),
        .o_done    (w_cordic_done),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    drp_smul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_done),
        .i_mult  (r_mag),
        .i_mcand (w_cos),
        .o_done  (w_mul_done_x),
        .o_delta (w_dx)
    );

    drp_smul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_done),
        .i_mult  (r_mag),
        .i_mcand (w_sin),
        .o_done  (w_mul_done_y),
        .o_delta (w_dy)
    );

    assign w_sum_x = 35'(r_x) + 35'(w_dx);
    assign w_sum_y = 35'(r_y) + 35'(w_dy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_item.operation)
                        OP_START:   n_state = ST_DONE;
                        OP_TURN:    n_state = ST_WRAP;
                        OP_ADVANCE: n_state = ST_CORDIC;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_WRAP: begin
                if (w_wrap_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_CORDIC: begin
                if (w_cordic_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mul_done_x) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_heading <= '0;
            r_clip    <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_clip <= 1'b0;
                if (i_in_item.operation == OP_START) begin
                    r_x       <= i_in_item.start_x;
                    r_y       <= i_in_item.start_y;
                    r_heading <= '0;
                end
            end
            if ((r_state == ST_WRAP) && w_wrap_done) begin
                r_heading <= w_wrap_heading;
            end
            if ((r_state == ST_MUL) && w_mul_done_x) begin
                r_x    <= clamp(w_sum_x);
                r_y    <= clamp(w_sum_y);
                r_clip <= is_clip(w_sum_x) || is_clip(w_sum_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mag <= i_in_item.magnitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out.pos_x       <= r_x;
            r_out.pos_y       <= r_y;
            r_out.heading_deg <= r_heading;
            r_out.saturated   <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading < FULL_TURN)
        else $error("Heading left the range of one full turn.");

    a_wrap_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wrap_done |-> (r_state == ST_WRAP))
        else $error("Heading reduction finished outside a turn.");

    a_cordic_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == ST_CORDIC))
        else $error("Rotation finished outside an advance.");

    a_mul_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_done_x == w_mul_done_y) && (!w_mul_done_x || (r_state == ST_MUL)))
        else $error("Multiplier lanes out of step.");

    a_clip_only_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRAP) |-> !r_clip)
        else $error("Saturation flag set during a turn.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && w_out_free) |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("Finished item was not presented.");

endmodule

`default_nettype wire

FILE: sim/tb_dead_reckoning_position_tracker.sv
// Self-checking testbench for the dead-reckoning position tracker: queued items are driven
// through the input handshake and every result item is checked against a built-in predictor.
// Depends on drp_pkg and the dead_reckoning_position_tracker RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_dead_reckoning_position_tracker;

    import drp_pkg::*;

    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam int         CORDIC_STEPS     = 24;
    localparam longint     FULL_CIRCLE      = 64'sd23592960;
    localparam longint     RIGHT_ANGLE      = 64'sd5898240;
    localparam longint     CORDIC_GAIN_INV  = 64'sd652032874;
    localparam longint     ROUND_HALF       = 64'sd536870912;
    localparam int         RANDOM_PER_PHASE = 483;
    localparam int         STUCK_LIMIT      = 2000;
    localparam int         DRAIN_CYCLES     = 100;
    localparam int         REPORT_LINES     = 100;

    typedef struct {
        t_in_item    item;
        int unsigned phase;
        bit          hold;
    } t_command;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    t_command    command_queue [$];
    t_out_item   predicted_fixes [$];
    int unsigned phase       = 0;
    int unsigned fill_phase  = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_errors    = 0;
    int unsigned n_results   = 0;

    int unsigned send_idle_pct [0:2] = '{15, 74, 0};
    int unsigned recv_stall_pct [0:2] = '{74, 15, 0};

    longint atan_deg_q24 [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    longint trk_x       = 0;
    longint trk_y       = 0;
    longint trk_heading = 0;

    dead_reckoning_position_tracker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_out_item dead_reckon(input t_in_item it);
        t_out_item r;
        longint    mag, h, q, z, cx, cy, dx, dy, co, si, nx, ny;
        bit        clip;
        mag  = $signed(it.magnitude);
        clip = 1'b0;
        case (it.operation)
            OP_START: begin
                trk_x       = $signed(it.start_x);
                trk_y       = $signed(it.start_y);
                trk_heading = 0;
            end
            OP_TURN: begin
                h = (trk_heading + mag) % FULL_CIRCLE;
                if (h < 0) begin
                    h += FULL_CIRCLE;
                end
                trk_heading = h;
            end
            OP_ADVANCE: begin
                q  = trk_heading / RIGHT_ANGLE;
                z  = (trk_heading - q * RIGHT_ANGLE) * 256;
                cx = CORDIC_GAIN_INV;
                cy = 0;
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (z >= 0) begin
                        cx -= dx;
                        cy += dy;
                        z  -= atan_deg_q24[i];
                    end else begin
                        cx += dx;
                        cy -= dy;
                        z  += atan_deg_q24[i];
                    end
                end
                case (q[1:0])
                    2'd0: begin co = cx;  si = cy;  end
                    2'd1: begin co = -cy; si = cx;  end
                    2'd2: begin co = -cx; si = -cy; end
                    default: begin co = cy; si = -cx; end
                endcase
                nx = trk_x + ((mag * co + ROUND_HALF) >>> 30);
                ny = trk_y + ((mag * si + ROUND_HALF) >>> 30);
                if (nx > longint'(POS_MAX)) begin nx = POS_MAX; clip = 1'b1; end
                if (nx < longint'(POS_MIN)) begin nx = POS_MIN; clip = 1'b1; end
                if (ny > longint'(POS_MAX)) begin ny = POS_MAX; clip = 1'b1; end
                if (ny < longint'(POS_MIN)) begin ny = POS_MIN; clip = 1'b1; end
                trk_x = nx;
                trk_y = ny;
            end
            default: begin
            end
        endcase
        r.pos_x       = trk_x[31:0];
        r.pos_y       = trk_y[31:0];
        r.heading_deg = trk_heading[24:0];
        r.saturated   = clip;
        return r;
    endfunction

    function automatic void queue_item(input logic [1:0] op, input logic [31:0] mag,
                                       input logic [31:0] x, input logic [31:0] y,
                                       input bit hold);
        t_command c;
        c.item.operation = op;
        c.item.magnitude = mag;
        c.item.start_x   = x;
        c.item.start_y   = y;
        c.phase          = fill_phase;
        c.hold           = hold;
        command_queue    = {command_queue, c};
    endfunction

    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
            2: v = POS_MAX - 32'($urandom_range(0, 1 << 24));
            default: v = POS_MIN + 32'($urandom_range(0, 1 << 24));
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= REPORT_LINES) begin
            $display("%0t ns: result %0d: %s", $time, n_results, what);
        end
    endtask

    always @(posedge clk) begin : driver
        t_command nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predicted_fixes = {predicted_fixes, dead_reckon(in_item)};
            end
            if (!in_valid || !in_stall) begin
                if (command_queue.size() != 0 &&
                    !(command_queue[0].hold && predicted_fixes.size() != 0) &&
                    (command_queue[0].hold ||
                     $urandom_range(99) >= send_idle_pct[command_queue[0].phase])) begin
                    nxt = command_queue.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= nxt.item;
                    phase    <= nxt.phase;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (predicted_fixes.size() == 0) begin
                    report_mismatch("result item with no item outstanding");
                end else begin
                    want = predicted_fixes.pop_front();
                    if (out_item.pos_x !== want.pos_x) begin
                        report_mismatch($sformatf("pos_x got %h expected %h",
                                                  out_item.pos_x, want.pos_x));
                    end
                    if (out_item.pos_y !== want.pos_y) begin
                        report_mismatch($sformatf("pos_y got %h expected %h",
                                                  out_item.pos_y, want.pos_y));
                    end
                    if (out_item.heading_deg !== want.heading_deg) begin
                        report_mismatch($sformatf("heading_deg got %h expected %h",
                                                  out_item.heading_deg, want.heading_deg));
                    end
                    if (out_item.saturated !== want.saturated) begin
                        report_mismatch($sformatf("saturated got %b expected %b",
                                                  out_item.saturated, want.saturated));
                    end
                end
                n_results++;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct[phase]);
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned sel;
        logic [1:0]  op;
        logic [31:0] mag, x, y;
        bit          hold;

        queue_item(OP_START, $urandom, POS_MAX, POS_MIN, 1'b1);
        queue_item(OP_ADVANCE, 32'h7FFF_FFFF, $urandom, $urandom, 1'b0);
        queue_item(OP_TURN, 32'(90 << 16), $urandom, $urandom, 1'b0);
        queue_item(OP_ADVANCE, 32'h8000_0000, $urandom, $urandom, 1'b0);
        queue_item(OP_TURN, 32'hFFFF_FFFF, $urandom, $urandom, 1'b0);
        queue_item(OP_TURN, 32'h7FFF_FFFF, $urandom, $urandom, 1'b0);
        queue_item(OP_TURN, 32'h8000_0000, $urandom, $urandom, 1'b0);
        queue_item(OP_TURN, 32'(360 << 16), $urandom, $urandom, 1'b0);
        queue_item(OP_TURN, -32'(360 << 16), $urandom, $urandom, 1'b0);
        queue_item(OP_UNUSED, $urandom, $urandom, $urandom, 1'b0);
        queue_item(OP_ADVANCE, 32'd0, $urandom, $urandom, 1'b0);
        queue_item(OP_START, $urandom, 32'd0, 32'd0, 1'b0);
        for (int k = 0; k < 8; k++) begin
            queue_item(OP_ADVANCE, 32'(100 << 16), $urandom, $urandom, 1'b0);
            queue_item(OP_TURN, 32'(45 << 16), $urandom, $urandom, 1'b0);
        end

        for (int ph = 0; ph < 3; ph++) begin
            fill_phase = ph;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                sel  = $urandom_range(99);
                hold = (n == 0) || ($urandom_range(99) == 0);
                mag  = $urandom;
                x    = $urandom;
                y    = $urandom;
                if (sel < 8) begin
                    op = OP_START;
                    x  = pick_coord();
                    y  = pick_coord();
                end else if (sel < 40) begin
                    op = OP_TURN;
                    case ($urandom_range(3))
                        0, 1: mag = 32'($urandom_range(0, 800 << 16)) - 32'(400 << 16);
                        2: mag = 32'($urandom_range(0, 15) * (45 << 16)) - 32'(360 << 16);
                        default: begin
                        end
                    endcase
                end else if (sel < 95) begin
                    op = OP_ADVANCE;
                    case ($urandom_range(4))
                        0, 1, 2: mag = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
                        3: begin
                        end
                        default: begin
                            case ($urandom_range(3))
                                0: mag = 32'h7FFF_FFFF;
                                1: mag = 32'h8000_0000;
                                2: mag = 32'd0;
                                default: mag = 32'd1;
                            endcase
                        end
                    endcase
                end else begin
                    op = OP_UNUSED;
                end
                queue_item(op, mag, x, y, hold);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while ((command_queue.size() != 0 || in_valid || predicted_fixes.size() != 0) &&
               idle_cycles < STUCK_LIMIT) begin
            @(posedge clk);
        end

        if (idle_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (n_errors == 0 && predicted_fixes.size() == 0) begin
                $display("PASS");
            end else begin
                $display("FAIL");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
